// ===== src/tsdes_pkg.sv =====
package tsdes_pkg;

  localparam int unsigned KEY_W  = 10;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned SK_W   = 8;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_KEY_ONE      = 2'd0;
  localparam reg_idx_t REG_KEY_TWO      = 2'd1;
  localparam reg_idx_t REG_TRIPLE_MODE  = 2'd2;
  localparam reg_idx_t REG_DECRYPT_MODE = 2'd3;

  typedef struct packed {
    logic [SK_W-1:0] k1;
    logic [SK_W-1:0] k2;
  } subkeys_t;

  localparam logic [1:0] SBOX0 [4][4] = '{
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd3, 2'd2, 2'd1, 2'd0},
    '{2'd0, 2'd2, 2'd1, 2'd3},
    '{2'd3, 2'd1, 2'd3, 2'd2}
  };

  localparam logic [1:0] SBOX1 [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd3, 2'd0, 2'd1, 2'd0},
    '{2'd2, 2'd1, 2'd0, 2'd3}
  };

  // permutations, positions counted from 1 at the msb
  function automatic logic [9:0] p10(input logic [9:0] k);
    return {k[7], k[5], k[8], k[3], k[6], k[0], k[9], k[1], k[2], k[4]};
  endfunction

  function automatic logic [7:0] p8(input logic [9:0] t);
    return {t[4], t[7], t[3], t[6], t[2], t[5], t[0], t[1]};
  endfunction

  function automatic logic [3:0] p4(input logic [3:0] s);
    return {s[2], s[0], s[1], s[3]};
  endfunction

  function automatic logic [7:0] ip(input logic [7:0] v);
    return {v[6], v[2], v[5], v[7], v[4], v[0], v[3], v[1]};
  endfunction

  function automatic logic [7:0] ip_inv(input logic [7:0] v);
    return {v[4], v[7], v[5], v[3], v[1], v[6], v[0], v[2]};
  endfunction

  function automatic logic [7:0] exp_perm(input logic [3:0] r);
    return {r[0], r[3], r[2], r[1], r[2], r[1], r[0], r[3]};
  endfunction

  function automatic logic [9:0] rot1_halves(input logic [9:0] v);
    return {v[8:5], v[9], v[3:0], v[4]};
  endfunction

  function automatic logic [9:0] rot2_halves(input logic [9:0] v);
    return {v[7:5], v[9:8], v[2:0], v[4:3]};
  endfunction

  function automatic subkeys_t make_subkeys(input logic [KEY_W-1:0] key);
    logic [9:0] t1;
    logic [9:0] t2;
    subkeys_t sk;
    t1 = rot1_halves(p10(key));
    t2 = rot2_halves(t1);
    sk.k1 = p8(t1);
    sk.k2 = p8(t2);
    return sk;
  endfunction

  function automatic logic [3:0] round_f(input logic [3:0] r, input logic [SK_W-1:0] sk);
    logic [7:0] x;
    logic [1:0] s0;
    logic [1:0] s1;
    x  = exp_perm(r) ^ sk;
    s0 = SBOX0[{x[7], x[4]}][x[6:5]];
    s1 = SBOX1[{x[3], x[0]}][x[2:1]];
    return p4({s0, s1});
  endfunction

  function automatic logic [7:0] round_fk(input logic [7:0] v, input logic [SK_W-1:0] sk);
    return {v[7:4] ^ round_f(v[3:0], sk), v[3:0]};
  endfunction

endpackage

// ===== src/tsdes_pass.sv =====
module tsdes_pass (
  input  tsdes_pkg::subkeys_t          subkeys,
  input  logic                         decrypt,
  input  logic [tsdes_pkg::DATA_W-1:0] din,
  output logic [tsdes_pkg::DATA_W-1:0] dout
);

  logic [tsdes_pkg::SK_W-1:0]   sk_a;
  logic [tsdes_pkg::SK_W-1:0]   sk_b;
  logic [tsdes_pkg::DATA_W-1:0] t_ip;
  logic [tsdes_pkg::DATA_W-1:0] t_r1;
  logic [tsdes_pkg::DATA_W-1:0] t_sw;
  logic [tsdes_pkg::DATA_W-1:0] t_r2;

  // decryption runs the subkeys in reverse order
  assign sk_a = decrypt ? subkeys.k2 : subkeys.k1;
  assign sk_b = decrypt ? subkeys.k1 : subkeys.k2;

  assign t_ip = tsdes_pkg::ip(din);
  assign t_r1 = tsdes_pkg::round_fk(t_ip, sk_a);
  assign t_sw = {t_r1[3:0], t_r1[7:4]};
  assign t_r2 = tsdes_pkg::round_fk(t_sw, sk_b);
  assign dout = tsdes_pkg::ip_inv(t_r2);

endmodule

// ===== src/triple_sdes_byte_cipher_unit.sv =====
// Simplified DES byte cipher, single or two-key triple (E-D-E) mode.
// Input channel: in_valid / in_ready with one byte in in_data_in per request.
// Result channel: out_valid / out_ready with one byte in out_data_out per request.
// Every request gives exactly one result, in order.
// Registers on the APB port: 0x0 key_one, 0x4 key_two, 0x8 triple_mode,
// 0xC decrypt_mode; write them only while no request is in flight.
// Path: an accepted byte is held in the input register, and its result is
// offered from the result register; one input register stage and one
// result register with all cipher rounds in between.
// Throughput: one byte per cycle while the receiver takes results; the three passes of triple mode are laid out
// side by side between the two registers.
// A stalled receiver holds the result register; the input register keeps
// accepting until it is also full, so in_ready drops only after both stages
// hold a byte.
// Reset (rst_n low, synchronous) empties both stages and clears the
// configuration registers to zero: single mode, encrypt, both keys zero.
module triple_sdes_byte_cipher_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tsdes_pkg::DATA_W-1:0]    in_data_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tsdes_pkg::DATA_W-1:0]    out_data_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tsdes_pkg::ADDR_W-1:0]    paddr,
  input  logic [tsdes_pkg::PDATA_W-1:0]   pwdata,
  output logic [tsdes_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready
);

  logic [tsdes_pkg::KEY_W-1:0]  key_one_r;
  logic [tsdes_pkg::KEY_W-1:0]  key_two_r;
  logic                         triple_mode_r;
  logic                         decrypt_mode_r;
  logic                         cfg_wr;
  tsdes_pkg::reg_idx_t          cfg_idx;

  logic                         s1_valid_r;
  logic [tsdes_pkg::DATA_W-1:0] s1_data_r;
  logic                         out_valid_r;
  logic [tsdes_pkg::DATA_W-1:0] out_data_r;
  logic                         s2_ready;
  logic                         s1_ready;

  tsdes_pkg::subkeys_t          sk_one;
  tsdes_pkg::subkeys_t          sk_two;
  logic [tsdes_pkg::DATA_W-1:0] pass0;
  logic [tsdes_pkg::DATA_W-1:0] pass1;
  logic [tsdes_pkg::DATA_W-1:0] pass2;
  logic [tsdes_pkg::DATA_W-1:0] result_nxt;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_one_r      <= '0;
      key_two_r      <= '0;
      triple_mode_r  <= 1'b0;
      decrypt_mode_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        tsdes_pkg::REG_KEY_ONE:      key_one_r      <= pwdata[tsdes_pkg::KEY_W-1:0];
        tsdes_pkg::REG_KEY_TWO:      key_two_r      <= pwdata[tsdes_pkg::KEY_W-1:0];
        tsdes_pkg::REG_TRIPLE_MODE:  triple_mode_r  <= pwdata[0];
        tsdes_pkg::REG_DECRYPT_MODE: decrypt_mode_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      tsdes_pkg::REG_KEY_ONE:
        prdata = {{(tsdes_pkg::PDATA_W-tsdes_pkg::KEY_W){1'b0}}, key_one_r};
      tsdes_pkg::REG_KEY_TWO:
        prdata = {{(tsdes_pkg::PDATA_W-tsdes_pkg::KEY_W){1'b0}}, key_two_r};
      tsdes_pkg::REG_TRIPLE_MODE:
        prdata = {{(tsdes_pkg::PDATA_W-1){1'b0}}, triple_mode_r};
      tsdes_pkg::REG_DECRYPT_MODE:
        prdata = {{(tsdes_pkg::PDATA_W-1){1'b0}}, decrypt_mode_r};
      default:
        prdata = '0;
    endcase
  end

  // two-stage pipeline handshake
  assign s2_ready = !out_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_data_r <= in_data_in;
    end
  end

  // subkeys follow the key registers
  assign sk_one = tsdes_pkg::make_subkeys(key_one_r);
  assign sk_two = tsdes_pkg::make_subkeys(key_two_r);

  tsdes_pass u_pass0 (
    .subkeys (sk_one),
    .decrypt (decrypt_mode_r),
    .din     (s1_data_r),
    .dout    (pass0)
  );

  tsdes_pass u_pass1 (
    .subkeys (sk_two),
    .decrypt (!decrypt_mode_r),
    .din     (pass0),
    .dout    (pass1)
  );

  tsdes_pass u_pass2 (
    .subkeys (sk_one),
    .decrypt (decrypt_mode_r),
    .din     (pass1),
    .dout    (pass2)
  );

  assign result_nxt = triple_mode_r ? pass2 : pass0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s2_ready) begin
      out_data_r <= result_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;

  // checks
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !out_valid_r)
    else $error("pipeline not empty after reset");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_ready |=> out_valid_r)
    else $error("request lost between stages");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled with room in the pipeline");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_ready |=> out_data_r == $past(result_nxt))
    else $error("result register not loaded");

endmodule
